// ===== rtl/gmtt_pkg.sv =====
package gmtt_pkg;

	// default sizes
	localparam int MAX_X_DEF       = 128;
	localparam int MAX_Y_DEF       = 128;
	localparam int SAMPLE_BITS_DEF = 32;

	// register reset values
	localparam logic [7:0]  BOX_XY_RST = 8'd128;
	localparam logic [15:0] BOX_Z_RST  = 16'd128;
	localparam logic [31:0] INV_RST    = 32'h0001_0000;
	localparam logic [31:0] THR_RST    = 32'hFFFF_FFFF;

	// threshold is doubled and moved to Q.16 before squaring: (thr << 17)^2
	localparam int THR_SQ_SHIFT = 34;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_BOX_X  = 3'd0,
		CFG_BOX_Y  = 3'd1,
		CFG_BOX_Z  = 3'd2,
		CFG_INV_DX = 3'd3,
		CFG_INV_DY = 3'd4,
		CFG_INV_DZ = 3'd5,
		CFG_THR    = 3'd6,
		CFG_TAG_EN = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  box_x;
		logic [7:0]  box_y;
		logic [15:0] box_z;
		logic [31:0] inv_dx;
		logic [31:0] inv_dy;
		logic [31:0] inv_dz;
		logic [31:0] thr;
		logic        tag_en;
	} cfg_t;

	// per-cell info that rides along the pipeline
	typedef struct packed {
		logic        vld;
		logic [6:0]  cell_x;
		logic [6:0]  cell_y;
		logic [15:0] cell_z;
		logic        done;
	} meta_t;

endpackage

// ===== rtl/gmtt_fetch.sv =====
module gmtt_fetch #(
	parameter int MAX_X       = gmtt_pkg::MAX_X_DEF,
	parameter int MAX_Y       = gmtt_pkg::MAX_Y_DEF,
	parameter int SAMPLE_BITS = gmtt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   pos_clr,
	input  gmtt_pkg::cfg_t         cfg,
	output gmtt_pkg::meta_t        meta_s1,
	output logic [SAMPLE_BITS-1:0] smp_s1,
	output logic [SAMPLE_BITS-1:0] xp_s1,
	output logic [SAMPLE_BITS-1:0] xm_s1,
	output logic [SAMPLE_BITS-1:0] yp_s1,
	output logic [SAMPLE_BITS-1:0] ym_s1,
	output logic [SAMPLE_BITS-1:0] zm_s1
);

	localparam int XLIM  = (MAX_X > 255) ? 255 : MAX_X;
	localparam int YLIM  = (MAX_Y > 255) ? 255 : MAX_Y;
	localparam int XW    = $clog2(XLIM);
	localparam int YW    = $clog2(YLIM);
	localparam int PLANE = MAX_X * MAX_Y;
	localparam int DEPTH = 2 * PLANE;
	localparam int AW    = $clog2(DEPTH);

	logic [XW-1:0] pos_x_q;
	logic [YW-1:0] pos_y_q;
	logic [15:0]   pos_z_q;
	logic          acc;
	logic          x_last, y_last, z_last;
	logic [AW-1:0] here, cur_base, prev_base;
	logic [AW-1:0] a_xp, a_xm, a_yp, a_ym, a_z;
	gmtt_pkg::meta_t meta_d;

	// three copies of the two-plane store, two read ports each at most
	logic [SAMPLE_BITS-1:0] mem_x [DEPTH];
	logic [SAMPLE_BITS-1:0] mem_y [DEPTH];
	logic [SAMPLE_BITS-1:0] mem_z [DEPTH];

	assign acc = in_valid & en;

	// raster position
	assign x_last = (9'(pos_x_q) + 9'd1) >= 9'(cfg.box_x);
	assign y_last = (9'(pos_y_q) + 9'd1) >= 9'(cfg.box_y);
	assign z_last = (17'(pos_z_q) + 17'd1) >= 17'(cfg.box_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (pos_clr) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (acc) begin
			if (x_last) begin
				pos_x_q <= '0;
				if (y_last) begin
					pos_y_q <= '0;
					pos_z_q <= z_last ? 16'd0 : pos_z_q + 16'd1;
				end else begin
					pos_y_q <= pos_y_q + YW'(1);
				end
			end else begin
				pos_x_q <= pos_x_q + XW'(1);
			end
		end
	end

	// store addresses: current plane holds z-2, the other holds z-1
	assign here      = AW'(pos_y_q) * AW'(MAX_X) + AW'(pos_x_q);
	assign cur_base  = pos_z_q[0] ? AW'(PLANE) : '0;
	assign prev_base = pos_z_q[0] ? '0 : AW'(PLANE);
	assign a_xp      = prev_base + here + AW'(1);
	assign a_xm      = prev_base + here - AW'(1);
	assign a_yp      = prev_base + here + AW'(MAX_X);
	assign a_ym      = prev_base + here - AW'(MAX_X);
	assign a_z       = cur_base + here;

	// interior cell whose stencil completes with this sample
	always_comb begin
		meta_d.vld    = acc && (pos_z_q >= 16'd2) && (pos_x_q != '0) && (pos_y_q != '0)
			&& ((9'(pos_x_q) + 9'd2) <= 9'(cfg.box_x))
			&& ((9'(pos_y_q) + 9'd2) <= 9'(cfg.box_y));
		meta_d.cell_x = 7'(pos_x_q - XW'(1));
		meta_d.cell_y = 7'(pos_y_q - YW'(1));
		meta_d.cell_z = pos_z_q - 16'd2;
		meta_d.done   = ((9'(pos_x_q) + 9'd2) == 9'(cfg.box_x))
			&& ((9'(pos_y_q) + 9'd2) == 9'(cfg.box_y))
			&& ((17'(pos_z_q) + 17'd1) == 17'(cfg.box_z));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s1 <= '0;
		end else if (en) begin
			meta_s1 <= meta_d;
		end
	end

	// store read (old data) and write
	always_ff @(posedge clk) begin
		if (acc) begin
			mem_x[a_z] <= sample;
			mem_y[a_z] <= sample;
			mem_z[a_z] <= sample;
		end
		if (en) begin
			xp_s1  <= mem_x[a_xp];
			xm_s1  <= mem_x[a_xm];
			yp_s1  <= mem_y[a_yp];
			ym_s1  <= mem_y[a_ym];
			zm_s1  <= mem_z[a_z];
			smp_s1 <= sample;
		end
	end

endmodule

// ===== rtl/gmtt_arith.sv =====
module gmtt_arith #(
	parameter int SAMPLE_BITS = gmtt_pkg::SAMPLE_BITS_DEF,
	parameter int SUMW        = 2 * (SAMPLE_BITS + 33) + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  gmtt_pkg::cfg_t         cfg,
	input  gmtt_pkg::meta_t        meta_s1,
	input  logic [SAMPLE_BITS-1:0] smp_s1,
	input  logic [SAMPLE_BITS-1:0] xp_s1,
	input  logic [SAMPLE_BITS-1:0] xm_s1,
	input  logic [SAMPLE_BITS-1:0] yp_s1,
	input  logic [SAMPLE_BITS-1:0] ym_s1,
	input  logic [SAMPLE_BITS-1:0] zm_s1,
	output gmtt_pkg::meta_t        meta_s7,
	output logic [SUMW-1:0]        sum_s7
);

	localparam int DW  = SAMPLE_BITS + 1;
	localparam int PW  = DW + 32;
	localparam int HW  = PW - 32;
	localparam int SQW = 2 * PW;

	logic [2:0][DW-1:0]     d_s2;
	logic [2:0][DW-1:0]     mag_s3;
	logic [2:0][PW-1:0]     p_s4;
	logic [2:0][2*HW-1:0]   hh_s5;
	logic [2:0][HW+31:0]    hl_s5;
	logic [2:0][63:0]       ll_s5;
	logic [2:0][SQW-1:0]    sq_s6;
	logic [2:0][31:0]       inv;
	gmtt_pkg::meta_t        meta_s2, meta_s3, meta_s4, meta_s5, meta_s6;

	assign inv[0] = cfg.inv_dx;
	assign inv[1] = cfg.inv_dy;
	assign inv[2] = cfg.inv_dz;

	// valid and cell info follow the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s2 <= '0;
			meta_s3 <= '0;
			meta_s4 <= '0;
			meta_s5 <= '0;
			meta_s6 <= '0;
			meta_s7 <= '0;
		end else if (en) begin
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
			meta_s5 <= meta_s4;
			meta_s6 <= meta_s5;
			meta_s7 <= meta_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s2: central differences
			d_s2[0] <= DW'($signed(xp_s1)) - DW'($signed(xm_s1));
			d_s2[1] <= DW'($signed(yp_s1)) - DW'($signed(ym_s1));
			d_s2[2] <= DW'($signed(smp_s1)) - DW'($signed(zm_s1));
			for (int i = 0; i < 3; i++) begin
				// s3: magnitude, fits unsigned DW bits
				mag_s3[i] <= d_s2[i][DW-1] ? (~d_s2[i] + DW'(1)) : d_s2[i];
				// s4: scale by inverse cell size
				p_s4[i]   <= PW'(mag_s3[i]) * PW'(inv[i]);
				// s5: partial products of the square
				hh_s5[i]  <= (2*HW)'(p_s4[i][PW-1:32]) * (2*HW)'(p_s4[i][PW-1:32]);
				hl_s5[i]  <= (HW+32)'(p_s4[i][PW-1:32]) * (HW+32)'(p_s4[i][31:0]);
				ll_s5[i]  <= 64'(p_s4[i][31:0]) * 64'(p_s4[i][31:0]);
				// s6: assemble the square
				sq_s6[i]  <= (SQW'(hh_s5[i]) << 64) + (SQW'(hl_s5[i]) << 33)
					+ SQW'(ll_s5[i]);
			end
			// s7: sum over axes
			sum_s7 <= SUMW'(sq_s6[0]) + SUMW'(sq_s6[1]) + SUMW'(sq_s6[2]);
		end
	end

endmodule

// ===== rtl/gradient_magnitude_threshold_tagger.sv =====
// A sample accepted into s1 runs through s2 to s7 into the output register s8;
// one sample per cycle unless stalled; any result order equals sample order.
// Throughput is set by the single-issue stencil pipeline; a stalled output holds
// every stage. Samples that complete no interior cell give no result.
// Reset clears position, pipeline valids and config to defaults; the plane store
// is not cleared and needs no clearing pass.
module gradient_magnitude_threshold_tagger #(
	parameter int MAX_X       = gmtt_pkg::MAX_X_DEF,
	parameter int MAX_Y       = gmtt_pkg::MAX_Y_DEF,
	parameter int SAMPLE_BITS = gmtt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   tag,
	output logic [6:0]             cell_x,
	output logic [6:0]             cell_y,
	output logic [15:0]            cell_z,
	output logic                   box_done,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [2:0]             cfg_index,
	input  logic [31:0]            cfg_data
);

	localparam int SUMW = 2 * (SAMPLE_BITS + 33) + 2;
	localparam int TW   = 64 + gmtt_pkg::THR_SQ_SHIFT;
	localparam int CW   = (SUMW > TW) ? SUMW : TW;
	localparam int BXM  = (MAX_X > 255) ? 255 : MAX_X;
	localparam int BYM  = (MAX_Y > 255) ? 255 : MAX_Y;
	localparam logic [7:0] BXR = (MAX_X < 128) ? 8'(MAX_X) : gmtt_pkg::BOX_XY_RST;
	localparam logic [7:0] BYR = (MAX_Y < 128) ? 8'(MAX_Y) : gmtt_pkg::BOX_XY_RST;

	gmtt_pkg::cfg_t         cfg_q;
	gmtt_pkg::meta_t        meta_s1, meta_s7, meta_s8;
	logic [63:0]            thr_sq_q;
	logic                   en, cfg_wr, pos_clr;
	logic [SAMPLE_BITS-1:0] smp_s1, xp_s1, xm_s1, yp_s1, ym_s1, zm_s1;
	logic [SUMW-1:0]        sum_s7;
	logic                   tag_s8;
	logic [7:0]             v8;
	logic [15:0]            v16;

	// whole pipeline moves unless the output register is full and held
	assign en        = ~meta_s8.vld | out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign pos_clr   = cfg_wr & (cfg_index inside {gmtt_pkg::CFG_BOX_X,
		gmtt_pkg::CFG_BOX_Y, gmtt_pkg::CFG_BOX_Z});
	assign v8        = cfg_data[7:0];
	assign v16       = cfg_data[15:0];

	// configuration registers, box sizes saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_x  <= BXR;
			cfg_q.box_y  <= BYR;
			cfg_q.box_z  <= gmtt_pkg::BOX_Z_RST;
			cfg_q.inv_dx <= gmtt_pkg::INV_RST;
			cfg_q.inv_dy <= gmtt_pkg::INV_RST;
			cfg_q.inv_dz <= gmtt_pkg::INV_RST;
			cfg_q.thr    <= gmtt_pkg::THR_RST;
			cfg_q.tag_en <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_index)
				gmtt_pkg::CFG_BOX_X: begin
					cfg_q.box_x <= (v8 < 8'd3) ? 8'd3 : ((v8 > 8'(BXM)) ? 8'(BXM) : v8);
				end
				gmtt_pkg::CFG_BOX_Y: begin
					cfg_q.box_y <= (v8 < 8'd3) ? 8'd3 : ((v8 > 8'(BYM)) ? 8'(BYM) : v8);
				end
				gmtt_pkg::CFG_BOX_Z:  cfg_q.box_z  <= (v16 < 16'd3) ? 16'd3 : v16;
				gmtt_pkg::CFG_INV_DX: cfg_q.inv_dx <= cfg_data;
				gmtt_pkg::CFG_INV_DY: cfg_q.inv_dy <= cfg_data;
				gmtt_pkg::CFG_INV_DZ: cfg_q.inv_dz <= cfg_data;
				gmtt_pkg::CFG_THR:    cfg_q.thr    <= cfg_data;
				gmtt_pkg::CFG_TAG_EN: cfg_q.tag_en <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// squared threshold, recomputed from the register every cycle
	always_ff @(posedge clk) begin
		thr_sq_q <= 64'(cfg_q.thr) * 64'(cfg_q.thr);
	end

	gmtt_fetch #(
		.MAX_X      (MAX_X),
		.MAX_Y      (MAX_Y),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_fetch (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.sample  (sample),
		.pos_clr (pos_clr),
		.cfg     (cfg_q),
		.meta_s1 (meta_s1),
		.smp_s1  (smp_s1),
		.xp_s1   (xp_s1),
		.xm_s1   (xm_s1),
		.yp_s1   (yp_s1),
		.ym_s1   (ym_s1),
		.zm_s1   (zm_s1)
	);

	gmtt_arith #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.SUMW       (SUMW)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cfg    (cfg_q),
		.meta_s1(meta_s1),
		.smp_s1 (smp_s1),
		.xp_s1  (xp_s1),
		.xm_s1  (xm_s1),
		.yp_s1  (yp_s1),
		.ym_s1  (ym_s1),
		.zm_s1  (zm_s1),
		.meta_s7(meta_s7),
		.sum_s7 (sum_s7)
	);

	// s8: threshold compare into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s8 <= '0;
		end else if (en) begin
			meta_s8 <= meta_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s8 <= cfg_q.tag_en
				& (CW'(sum_s7) > (CW'(thr_sq_q) << gmtt_pkg::THR_SQ_SHIFT));
		end
	end

	assign out_valid = meta_s8.vld;
	assign tag       = tag_s8;
	assign cell_x    = meta_s8.cell_x;
	assign cell_y    = meta_s8.cell_y;
	assign cell_z    = meta_s8.cell_z;
	assign box_done  = meta_s8.done;

endmodule
